// ===== hdl/rag_pkg.sv =====
// Shared constants, types and operation codes of the rational accumulator.
`timescale 1ns / 1ps

package rag_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = $clog2(WORD_BITS);

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic        [WORD_BITS-1:0] mag_t;
	typedef logic        [WORD_BITS:0]   rem_t;
	typedef logic        [CNT_BITS-1:0]  cnt_t;

	localparam cnt_t CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_ADD  = 2'd1,
		FUNC_MUL  = 2'd2,
		FUNC_DIV  = 2'd3
	} func_t;

endpackage

// ===== hdl/rag_if.sv =====
// Valid/ready channels that carry operation items in and result items out.
`timescale 1ns / 1ps

interface rag_req_if import rag_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	word_t operand_numerator;
	word_t operand_denominator;

	modport source (output valid, func, operand_numerator, operand_denominator, input ready);
	modport sink   (input valid, func, operand_numerator, operand_denominator, output ready);
endinterface

interface rag_rsp_if import rag_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t result_numerator;
	word_t result_denominator;
	logic  zero_denominator;

	modport source (output valid, result_numerator, result_denominator, zero_denominator,
		input ready);
	modport sink   (input valid, result_numerator, result_denominator, zero_denominator,
		output ready);
endinterface

// ===== hdl/rational_accumulator_gcd_reduce_top.sv =====
// Rational accumulator: bit-serial multiply, binary gcd and serial division by the gcd.
`timescale 1ns / 1ps

// The block keeps one fraction, a signed numerator and denominator of WORD_BITS bits, and
// takes one item at a time on the request channel: load stores the operand fraction as it
// is, while add, multiply and divide combine it with the stored fraction, with every product
// and sum wrapping at the word width. After an arithmetic operation both parts are divided by
// the gcd of their magnitudes; signs are kept as they come, and a zero part leaves the
// fraction unreduced. Every item gives exactly one result item, which also flags a zero
// denominator. A load goes from idle straight to the finish state. An arithmetic item
// passes the multiply, reduce, gcd, divide, sign and finish states: the products are formed
// one multiplier bit per cycle, the gcd loop removes one factor of two or does one
// subtraction per cycle, and both quotients are then formed one bit per cycle by a
// restoring divider. When either part of the new fraction is zero, the gcd and the
// division are skipped and the item goes from the reduce state to the finish state. A new
// item is taken as soon as the previous result sits in the output register, even if that
// result has not yet been collected; the new item then waits in its last step for as long
// as the receiver stalls the older result.

module rational_accumulator_gcd_reduce_top import rag_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rag_req_if.sink   request,
	rag_rsp_if.source response
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_RED  = 7'b0000100,
		ST_GCD  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_SIGN = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;

	// Stored fraction, held as raw two's complement words.
	mag_t acc_num_q, acc_den_q;

	// Bit-serial multipliers: the numerator is the sum of products a and b.
	mag_t mca_q, mpa_q, pa_q;
	mag_t mcb_q, mpb_q, pb_q;
	mag_t mcc_q, mpc_q, pc_q;
	mag_t set_mca, set_mpa, set_mcb, set_mpb, set_mcc, set_mpc;

	// Binary gcd operands and the magnitudes with the common power of two removed.
	mag_t ga_q, gb_q, sn_q, sd_q;
	logic neg_n_q, neg_d_q;

	// Restoring dividers for both quotients, sharing one divisor.
	mag_t div_q, qn_q, qd_q, rn_q, rd_q;
	rem_t rn_sh, rd_sh, rn_sub, rd_sub;
	logic rn_ge, rd_ge;

	// Output register.
	logic  out_valid_q;
	word_t out_num_q, out_den_q;
	logic  out_zero_q;

	logic accept, out_free;
	mag_t sum_num, mag_num, mag_den, gcd_diff;

	assign request.ready = (state_q == ST_IDLE);
	assign accept        = request.valid && request.ready;
	assign out_free      = !out_valid_q || response.ready;

	assign response.valid              = out_valid_q;
	assign response.result_numerator   = out_num_q;
	assign response.result_denominator = out_den_q;
	assign response.zero_denominator   = out_zero_q;

	// Operand routing for the three products; unused product b is zero.
	always_comb begin
		set_mca = acc_num_q;
		set_mpa = mag_t'(request.operand_denominator);
		set_mcb = '0;
		set_mpb = '0;
		set_mcc = acc_den_q;
		set_mpc = mag_t'(request.operand_denominator);
		case (request.func)
			FUNC_ADD: begin
				set_mcb = mag_t'(request.operand_numerator);
				set_mpb = acc_den_q;
			end
			FUNC_MUL: begin
				set_mpa = mag_t'(request.operand_numerator);
			end
			FUNC_DIV: begin
				set_mpc = mag_t'(request.operand_numerator);
			end
			default: begin
			end
		endcase
	end

	assign sum_num  = pa_q + pb_q;
	assign mag_num  = sum_num[WORD_BITS-1] ? mag_t'(-sum_num) : sum_num;
	assign mag_den  = pc_q[WORD_BITS-1] ? mag_t'(-pc_q) : pc_q;
	assign gcd_diff = (ga_q > gb_q) ? (ga_q - gb_q) : (gb_q - ga_q);

	// One quotient bit per cycle for each part.
	assign rn_sh  = {rn_q, qn_q[WORD_BITS-1]};
	assign rd_sh  = {rd_q, qd_q[WORD_BITS-1]};
	assign rn_ge  = (rn_sh >= {1'b0, div_q});
	assign rd_ge  = (rd_sh >= {1'b0, div_q});
	assign rn_sub = rn_sh - {1'b0, div_q};
	assign rd_sub = rd_sh - {1'b0, div_q};

	// Control and stored fraction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_num_q   <= '0;
			acc_den_q   <= mag_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills when a finished item moves in and empties when
			// the receiver takes its item.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (request.func == FUNC_LOAD) begin
							acc_num_q <= mag_t'(request.operand_numerator);
							acc_den_q <= mag_t'(request.operand_denominator);
							state_q   <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					acc_num_q <= sum_num;
					acc_den_q <= pc_q;
					if (sum_num == '0 || pc_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_GCD;
					end
				end
				ST_GCD: begin
					cnt_q <= '0;
					if (ga_q == gb_q) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					acc_num_q <= neg_n_q ? mag_t'(-qn_q) : qn_q;
					acc_den_q <= neg_d_q ? mag_t'(-qd_q) : qd_q;
					state_q   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Serial datapath and output payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mca_q <= set_mca;
				mpa_q <= set_mpa;
				mcb_q <= set_mcb;
				mpb_q <= set_mpb;
				mcc_q <= set_mcc;
				mpc_q <= set_mpc;
				pa_q  <= '0;
				pb_q  <= '0;
				pc_q  <= '0;
			end
			ST_MUL: begin
				pa_q  <= pa_q + (mpa_q[0] ? mca_q : '0);
				pb_q  <= pb_q + (mpb_q[0] ? mcb_q : '0);
				pc_q  <= pc_q + (mpc_q[0] ? mcc_q : '0);
				mca_q <= mca_q << 1;
				mcb_q <= mcb_q << 1;
				mcc_q <= mcc_q << 1;
				mpa_q <= mpa_q >> 1;
				mpb_q <= mpb_q >> 1;
				mpc_q <= mpc_q >> 1;
			end
			ST_RED: begin
				ga_q    <= mag_num;
				gb_q    <= mag_den;
				sn_q    <= mag_num;
				sd_q    <= mag_den;
				neg_n_q <= sum_num[WORD_BITS-1];
				neg_d_q <= pc_q[WORD_BITS-1];
			end
			ST_GCD: begin
				if (ga_q == gb_q) begin
					// The odd part of the gcd divides the magnitudes once the shared
					// power of two has been shifted out of them.
					div_q <= ga_q;
					qn_q  <= sn_q;
					qd_q  <= sd_q;
					rn_q  <= '0;
					rd_q  <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					sn_q <= sn_q >> 1;
					sd_q <= sd_q >> 1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q > gb_q) begin
					ga_q <= gcd_diff;
				end else begin
					gb_q <= gcd_diff;
				end
			end
			ST_DIV: begin
				rn_q <= rn_ge ? rn_sub[WORD_BITS-1:0] : rn_sh[WORD_BITS-1:0];
				rd_q <= rd_ge ? rd_sub[WORD_BITS-1:0] : rd_sh[WORD_BITS-1:0];
				qn_q <= {qn_q[WORD_BITS-2:0], rn_ge};
				qd_q <= {qd_q[WORD_BITS-2:0], rd_ge};
			end
			ST_FIN: begin
				if (out_free) begin
					out_num_q  <= word_t'(acc_num_q);
					out_den_q  <= word_t'(acc_den_q);
					out_zero_q <= (acc_den_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/rag_checker.sv =====
// Port-level checks of the rational accumulator and their binding to the top level.
`timescale 1ns / 1ps

module rag_checker import rag_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  req_valid,
	input logic  req_ready,
	input logic  rsp_valid,
	input logic  rsp_ready,
	input word_t rsp_numerator,
	input word_t rsp_denominator,
	input logic  rsp_zero
);

	// The block works on one item at a time, so it is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request ready stayed high after an item was accepted");

	// The flag must agree with the denominator it travels with.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_zero == (rsp_denominator == '0)))
		else $error("zero_denominator disagrees with result_denominator");

	// A result that is not taken stays put.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_numerator) && $stable(rsp_denominator)))
		else $error("stalled result item changed or was dropped");

endmodule

bind rational_accumulator_gcd_reduce_top rag_checker u_rag_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (request.valid),
	.req_ready       (request.ready),
	.rsp_valid       (response.valid),
	.rsp_ready       (response.ready),
	.rsp_numerator   (response.result_numerator),
	.rsp_denominator (response.result_denominator),
	.rsp_zero        (response.zero_denominator)
);
